@@ src/acc_pkg.sv @@
// Shared types, codes and helpers for the alarm clock controller.
package acc_pkg;

  // Mode machine, one-hot encoded
  typedef enum logic [3:0] {
    MODE_CLOCK   = 4'b0001,
    MODE_ALARM   = 4'b0010,
    MODE_GENERAL = 4'b0100,
    MODE_RING    = 4'b1000
  } mode_e;

  // Mode codes as seen on the result beat
  localparam logic [1:0] MODE_CODE_CLOCK   = 2'd0;
  localparam logic [1:0] MODE_CODE_ALARM   = 2'd1;
  localparam logic [1:0] MODE_CODE_GENERAL = 2'd2;
  localparam logic [1:0] MODE_CODE_RING    = 2'd3;

  // Alarm setting steps
  localparam logic ASTEP_HOUR   = 1'b0;
  localparam logic ASTEP_MINUTE = 1'b1;

  // General setting steps
  localparam logic [2:0] GSTEP_HOUR   = 3'd0;
  localparam logic [2:0] GSTEP_MINUTE = 3'd1;
  localparam logic [2:0] GSTEP_FORMAT = 3'd2;
  localparam logic [2:0] GSTEP_SOURCE = 3'd3;
  localparam logic [2:0] GSTEP_DONE   = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_PERIOD   = 2'd1;
  localparam logic [1:0] REG_ALARM_EN = 2'd2;

  // Register reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd200;
  localparam logic [19:0] PERIOD_RST   = 20'd60000;
  localparam logic        ALARM_EN_RST = 1'b1;

  // Time limits
  localparam logic [4:0] HOURS_MAX   = 5'd23;
  localparam logic [5:0] MINUTES_MAX = 6'd59;

  // State reset values
  localparam logic [4:0] ALARM_HOUR_RST   = 5'd7;
  localparam logic [5:0] ALARM_MINUTE_RST = 6'd30;
  localparam logic [4:0] CLOCK_HOUR_RST   = 5'd10;
  localparam logic [5:0] CLOCK_MINUTE_RST = 6'd0;

  typedef struct packed {
    logic        mode_button;
    logic        up_button;
    logic        down_button;
    logic        set_button;
    logic [31:0] now_ms;
    logic        ext_time_valid;
    logic [4:0]  ext_hour;
    logic [5:0]  ext_minute;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       alarm_step;
    logic [2:0] general_step;
    logic [4:0] alarm_hour_out;
    logic [5:0] alarm_minute_out;
    logic [4:0] clock_hour_out;
    logic [5:0] clock_minute_out;
    logic       format_24h_out;
    logic       external_time_out;
    logic       alarm_fired;
  } out_item_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [19:0] minute_period_ms;
    logic        alarm_enable;
  } cfg_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    case (m)
      MODE_CLOCK:   c = MODE_CODE_CLOCK;
      MODE_ALARM:   c = MODE_CODE_ALARM;
      MODE_GENERAL: c = MODE_CODE_GENERAL;
      MODE_RING:    c = MODE_CODE_RING;
      default:      c = MODE_CODE_CLOCK;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] hour_step(logic [4:0] v, logic up, logic dn);
    logic [4:0] r;
    r = v;
    if (up) begin
      r = (v == HOURS_MAX) ? 5'd0 : v + 5'd1;
    end else if (dn) begin
      r = (v == 5'd0) ? HOURS_MAX : v - 5'd1;
    end
    return r;
  endfunction

  function automatic logic [5:0] minute_step(logic [5:0] v, logic up, logic dn);
    logic [5:0] r;
    r = v;
    if (up) begin
      r = (v == MINUTES_MAX) ? 6'd0 : v + 6'd1;
    end else if (dn) begin
      r = (v == 6'd0) ? MINUTES_MAX : v - 6'd1;
    end
    return r;
  endfunction

endpackage

@@ src/alarm_clock_controller_top.sv @@
// Top level: stream ports, input and result registers, APB register file.
// An input beat passes the input register, then the result register, to m_axis.
// Throughput: 1 beat per cycle unless m_axis stalls; the controller state
// updates in one pass between the input register and the result register.
// A stalled result register holds the item in the input register; no bubbles.
// Reset (rst_ni low, asynchronous) restores valid flags, config and state.
module alarm_clock_controller_top import acc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: mode_button[0], up_button[1], down_button[2], set_button[3],
  //        now_ms[35:4], ext_time_valid[36], ext_hour[41:37], ext_minute[47:42]
  input  logic [47:0] s_axis_tdata,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: mode[1:0], alarm_step[2], general_step[5:3], alarm_hour_out[10:6],
  //        alarm_minute_out[16:11], clock_hour_out[21:17],
  //        clock_minute_out[27:22], format_24h_out[28], external_time_out[29],
  //        alarm_fired[30], zero[31]
  output logic [31:0] m_axis_tdata,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic      in_vld_q;
  in_item_t  in_item_q;
  logic      out_vld_q;
  out_item_t out_item_q;
  logic      advance;
  cfg_t      cfg_q;
  out_item_t result;
  logic [1:0] reg_idx;

  // Handshake: the item in the input register moves when the result slot frees
  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.mode_button    <= s_axis_tdata[0];
      in_item_q.up_button      <= s_axis_tdata[1];
      in_item_q.down_button    <= s_axis_tdata[2];
      in_item_q.set_button     <= s_axis_tdata[3];
      in_item_q.now_ms         <= s_axis_tdata[35:4];
      in_item_q.ext_time_valid <= s_axis_tdata[36];
      in_item_q.ext_hour       <= s_axis_tdata[41:37];
      in_item_q.ext_minute     <= s_axis_tdata[47:42];
    end
  end

  acc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0,
                          out_item_q.alarm_fired,
                          out_item_q.external_time_out,
                          out_item_q.format_24h_out,
                          out_item_q.clock_minute_out,
                          out_item_q.clock_hour_out,
                          out_item_q.alarm_minute_out,
                          out_item_q.alarm_hour_out,
                          out_item_q.general_step,
                          out_item_q.alarm_step,
                          out_item_q.mode};

  // Configuration registers
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms      <= DEBOUNCE_RST;
      cfg_q.minute_period_ms <= PERIOD_RST;
      cfg_q.alarm_enable     <= ALARM_EN_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_DEBOUNCE: cfg_q.debounce_ms      <= pwdata[15:0];
        REG_PERIOD:   cfg_q.minute_period_ms <= pwdata[19:0];
        REG_ALARM_EN: cfg_q.alarm_enable     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: prdata = {16'd0, cfg_q.debounce_ms};
      REG_PERIOD:   prdata = {12'd0, cfg_q.minute_period_ms};
      REG_ALARM_EN: prdata = {31'd0, cfg_q.alarm_enable};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

@@ src/acc_core.sv @@
// Controller state and the single-pass update for one registered item.
module acc_core import acc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  mode_e       mode_q, mode_d;
  logic        astep_q, astep_d;
  logic [2:0]  gstep_q, gstep_d;
  logic [4:0]  ahour_q, ahour_d;
  logic [5:0]  amin_q, amin_d;
  logic [4:0]  chour_q, chour_d;
  logic [5:0]  cmin_q, cmin_d;
  logic        fmt_q, fmt_d;
  logic        ext_q, ext_d;
  logic        latch_q, latch_d;
  logic [31:0] press_q, press_d;
  logic [31:0] tick_q, tick_d;
  logic        fired;

  // Next-state logic: debounce, mode machine, time base, alarm check
  always_comb begin
    logic       any_btn;
    logic       press;
    logic       done;
    logic       up;
    logic       dn;
    logic       have;
    logic [4:0] cmp_h;
    logic [5:0] cmp_m;

    mode_d  = mode_q;
    astep_d = astep_q;
    gstep_d = gstep_q;
    ahour_d = ahour_q;
    amin_d  = amin_q;
    chour_d = chour_q;
    cmin_d  = cmin_q;
    fmt_d   = fmt_q;
    ext_d   = ext_q;
    latch_d = latch_q;
    press_d = press_q;
    tick_d  = tick_q;
    fired   = 1'b0;
    done    = 1'b0;
    press   = 1'b0;
    up      = item_i.up_button;
    dn      = item_i.down_button & ~item_i.up_button;

    any_btn = item_i.mode_button | item_i.up_button | item_i.down_button | item_i.set_button;

    // Debounce: timestamp clears while released
    if (!any_btn) begin
      press_d = 32'd0;
    end else if ((item_i.now_ms - press_q) >= {16'd0, cfg_i.debounce_ms}) begin
      press_d = item_i.now_ms;
      press   = 1'b1;
    end

    if (press) begin
      if (mode_d == MODE_RING) begin
        mode_d = MODE_CLOCK;
        done   = 1'b1;
      end else if (mode_d == MODE_CLOCK) begin
        if (item_i.mode_button) begin
          mode_d  = MODE_ALARM;
          astep_d = ASTEP_HOUR;
        end else if (item_i.down_button) begin
          mode_d  = MODE_GENERAL;
          gstep_d = GSTEP_HOUR;
        end
      end else if (item_i.mode_button) begin
        mode_d = MODE_CLOCK;
        done   = 1'b1;
      end

      // The same press is then handled by the (possibly new) mode
      if (!done && mode_d == MODE_ALARM) begin
        if (astep_d == ASTEP_HOUR) begin
          ahour_d = hour_step(ahour_q, up, dn);
        end else begin
          amin_d = minute_step(amin_q, up, dn);
        end
        if (item_i.set_button) begin
          if (astep_d == ASTEP_HOUR) begin
            astep_d = ASTEP_MINUTE;
          end else begin
            mode_d = MODE_CLOCK;
          end
        end
      end else if (!done && mode_d == MODE_GENERAL) begin
        case (gstep_d)
          GSTEP_HOUR: begin
            chour_d = hour_step(chour_q, up, dn);
            if (item_i.set_button) gstep_d = GSTEP_MINUTE;
          end
          GSTEP_MINUTE: begin
            cmin_d = minute_step(cmin_q, up, dn);
            if (item_i.set_button) gstep_d = GSTEP_FORMAT;
          end
          GSTEP_FORMAT: begin
            if (item_i.up_button | item_i.down_button) fmt_d = ~fmt_q;
            if (item_i.set_button) gstep_d = GSTEP_SOURCE;
          end
          GSTEP_SOURCE: begin
            if (item_i.up_button | item_i.down_button) ext_d = ~ext_q;
            if (item_i.set_button) begin
              gstep_d = GSTEP_DONE;
              mode_d  = MODE_CLOCK;
            end
          end
          default: ;
        endcase
      end
    end

    // Manual time base, one minute per period
    if (mode_d == MODE_CLOCK && !ext_d) begin
      if ((item_i.now_ms - tick_q) >= {12'd0, cfg_i.minute_period_ms}) begin
        tick_d = item_i.now_ms;
        if (cmin_d == MINUTES_MAX) begin
          cmin_d  = 6'd0;
          chour_d = (chour_d == HOURS_MAX) ? 5'd0 : chour_d + 5'd1;
        end else begin
          cmin_d = cmin_d + 6'd1;
        end
      end
    end

    // Alarm compare, fires once per matching minute
    have  = ext_d ? item_i.ext_time_valid : 1'b1;
    cmp_h = ext_d ? item_i.ext_hour : chour_d;
    cmp_m = ext_d ? item_i.ext_minute : cmin_d;
    if (mode_d == MODE_CLOCK && cfg_i.alarm_enable && have) begin
      if (cmp_h == ahour_d && cmp_m == amin_d && !latch_q) begin
        mode_d  = MODE_RING;
        latch_d = 1'b1;
        fired   = 1'b1;
      end else if (cmp_m != amin_d) begin
        latch_d = 1'b0;
      end
    end
  end

  // State registers, updated once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_CLOCK;
      astep_q <= ASTEP_HOUR;
      gstep_q <= GSTEP_HOUR;
      ahour_q <= ALARM_HOUR_RST;
      amin_q  <= ALARM_MINUTE_RST;
      chour_q <= CLOCK_HOUR_RST;
      cmin_q  <= CLOCK_MINUTE_RST;
      fmt_q   <= 1'b1;
      ext_q   <= 1'b1;
      latch_q <= 1'b0;
      press_q <= 32'd0;
      tick_q  <= 32'd0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      astep_q <= astep_d;
      gstep_q <= gstep_d;
      ahour_q <= ahour_d;
      amin_q  <= amin_d;
      chour_q <= chour_d;
      cmin_q  <= cmin_d;
      fmt_q   <= fmt_d;
      ext_q   <= ext_d;
      latch_q <= latch_d;
      press_q <= press_d;
      tick_q  <= tick_d;
    end
  end

  // Result beat reflects the updated state
  always_comb begin
    result_o.mode              = mode_code(mode_d);
    result_o.alarm_step        = astep_d;
    result_o.general_step      = gstep_d;
    result_o.alarm_hour_out    = ahour_d;
    result_o.alarm_minute_out  = amin_d;
    result_o.clock_hour_out    = chour_d;
    result_o.clock_minute_out  = cmin_d;
    result_o.format_24h_out    = fmt_d;
    result_o.external_time_out = ext_d;
    result_o.alarm_fired       = fired;
  end

endmodule
